[src/rvm_polarization_chi_square_macros.svh]
// assertion macros for the rotating-vector-model chi-square block
// used by the port checker, no other dependencies
`ifndef RVM_POLARIZATION_CHI_SQUARE_MACROS_SVH
`define RVM_POLARIZATION_CHI_SQUARE_MACROS_SVH

// same-cycle implication
`define RVM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvm checker: implication failed");

// next-cycle implication
`define RVM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvm checker: next-cycle implication failed");

`endif

[src/rvm_pcs_pkg.sv]
// shared constants, types and tables for the rvm chi-square block
// no dependencies
`timescale 1ns / 1ps

package rvm_pcs_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_N = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int CNT_W = $clog2(CORDIC_N);

  localparam int ANG_W = 16;
  localparam int W_W = 24;
  localparam int SMP_W = 16;
  localparam int RES_W = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [RES_W-1:0] MAX48 = {RES_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA    = 3'd0,
    REG_BETA     = 3'd1,
    REG_PHASE    = 3'd2,
    REG_PSI      = 3'd3,
    REG_WEIGHT_Q = 3'd4,
    REG_WEIGHT_U = 3'd5
  } cfg_reg_t;

  // arctangent of 2^-i in 32-bit turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

[src/rvm_pcs_if.sv]
// handshake channels for bin words and result words
// uses rvm_pcs_pkg widths
`timescale 1ns / 1ps

interface rvm_pcs_in_if;
  logic valid;
  logic ready;
  logic [rvm_pcs_pkg::ANG_W-1:0] pulse_phase;
  logic signed [rvm_pcs_pkg::SMP_W-1:0] stokes_q;
  logic signed [rvm_pcs_pkg::SMP_W-1:0] stokes_u;
  logic last_bin;
  modport source(output valid, pulse_phase, stokes_q, stokes_u, last_bin, input ready);
  modport sink(input valid, pulse_phase, stokes_q, stokes_u, last_bin, output ready);
endinterface

interface rvm_pcs_out_if;
  logic valid;
  logic ready;
  logic [rvm_pcs_pkg::RES_W-1:0] point_term;
  logic [rvm_pcs_pkg::RES_W-1:0] chi_square_sum;
  logic sum_complete;
  logic sum_saturated;
  modport source(output valid, point_term, chi_square_sum, sum_complete, sum_saturated,
                 input ready);
  modport sink(input valid, point_term, chi_square_sum, sum_complete, sum_saturated,
               output ready);
endinterface

[src/rvm_polarization_chi_square.sv]
// rotating-vector-model chi-square, one shared cordic, multiplier and divider
// depends on rvm_pcs_pkg and rvm_pcs_if
`timescale 1ns / 1ps

// usage
// sample: one pulse-phase bin word (phase, stokes q and u, last-bin mark)
// result: one word per bin with the point term, the running sum and flags
// cfg: write enable, register index and data; write only while idle
// a bin word is taken only while the sequencer is idle; it then runs
// four cordic rotations and one cordic vectoring pass (n = 16 steps each),
// a short multiply sequence, a 57-step restoring divide and two weighted
// squares on one 34x34 multiplier
// the vectoring pass is skipped when the geometry is degenerate, and the
// divide when the weighted denominator is zero; the next word is taken
// once the sequencer is back in idle after loading the output register
// the result sits in an output register; a stalled receiver holds the
// finished word there and the sequencer waits with the next result
// reset clears the running sum, the saturation flag and the output valid,
// and sets angles to zero and weights to one
// after a word marked last_bin the sum and saturation flag clear

module rvm_polarization_chi_square (
  input  logic clk,
  input  logic rst,
  rvm_pcs_in_if.sink sample,
  rvm_pcs_out_if.source result,
  input  logic cfg_write,
  input  logic [rvm_pcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvm_pcs_pkg::W_W-1:0] cfg_data
);

  localparam int N = rvm_pcs_pkg::CORDIC_N;
  localparam int CW = rvm_pcs_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(N - 1);
  localparam logic signed [35:0] CORDIC_START = 36'sd652032874;
  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF = 34'sd2147483648;
  localparam logic [44:0] LN_LIMIT = 45'h100000000000;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_ROT_LOAD = 11'b000_0000_0010,
    ST_ROT_ITER = 11'b000_0000_0100,
    ST_ROT_DONE = 11'b000_0000_1000,
    ST_VEC_LOAD = 11'b000_0001_0000,
    ST_VEC_ITER = 11'b000_0010_0000,
    ST_MUL      = 11'b000_0100_0000,
    ST_DIV_LOAD = 11'b000_1000_0000,
    ST_DIV_ITER = 11'b001_0000_0000,
    ST_DIV_DONE = 11'b010_0000_0000,
    ST_FIN      = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    ROT_ALPHA = 2'd0,
    ROT_SUM   = 2'd1,
    ROT_DIFF  = 2'd2,
    ROT_PA    = 2'd3
  } rot_t;

  typedef enum logic [4:0] {
    STEP_K0, STEP_K1, STEP_K2, STEP_K3, STEP_K4,
    STEP_L0, STEP_L1, STEP_L2, STEP_L3, STEP_L4, STEP_L5, STEP_L6, STEP_L7, STEP_L8,
    STEP_R0, STEP_R1, STEP_R2, STEP_R3,
    STEP_W0, STEP_W1, STEP_W2, STEP_W3, STEP_W4, STEP_W5, STEP_W6, STEP_W7
  } step_t;

  function automatic logic signed [17:0] to_q16(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd8192) >>> 14;
    if (t > 36'sd65536) t = 36'sd65536;
    if (t < -36'sd65536) t = -36'sd65536;
    return 18'(t);
  endfunction

  state_t state;
  rot_t rot_idx;
  step_t step;

  logic [15:0] alpha_angle, beta_angle, phase_offset, angle_offset;
  logic [23:0] weight_q, weight_u;

  logic [15:0] phase_in;
  logic signed [15:0] q_in, u_in;
  logic last_in;

  logic [CW-1:0] cnt;
  logic signed [35:0] x, y;
  logic signed [33:0] z;
  logic vec_mode, rot_neg;

  logic signed [33:0] sa, ca, sx, cx, sd, cd, k1, k2;
  logic [31:0] two_pa;
  logic signed [17:0] c16, s16;

  logic signed [67:0] prod;
  logic signed [57:0] num, den;
  logic signed [95:0] acc;
  logic [56:0] dq;
  logic [41:0] rem;
  logic [5:0] dcnt;
  logic signed [45:0] ln;
  logic sel;
  logic [47:0] mag;
  logic [47:0] term;

  logic [47:0] running;
  logic sat_flag;

  logic o_valid, o_complete, o_sat;
  logic [47:0] o_term, o_sum;

  // cordic step
  logic signed [35:0] dx, dy, x_next, y_next;
  logic signed [33:0] at, z_next;
  logic up;

  always_comb begin
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = $signed({2'b00, rvm_pcs_pkg::atan_turn(5'(cnt))});
    up = vec_mode ? y[35] : !z[33];
    x_next = up ? x - dx : x + dx;
    y_next = up ? y + dy : y - dy;
    z_next = up ? z - at : z + at;
  end

  // rotation angle setup
  logic [31:0] psi2, rot_ang;
  logic [15:0] ab_sum, ph_diff;
  logic signed [33:0] zs, z_load;
  logic neg_load;
  logic signed [35:0] x_fin;

  always_comb begin
    psi2 = {angle_offset[14:0], 17'b0};
    ab_sum = alpha_angle + beta_angle;
    ph_diff = phase_in - phase_offset;
    case (rot_idx)
      ROT_ALPHA: rot_ang = {alpha_angle, 16'b0};
      ROT_SUM:   rot_ang = {ab_sum, 16'b0};
      ROT_DIFF:  rot_ang = {ph_diff, 16'b0};
      default:   rot_ang = two_pa;
    endcase
    zs = $signed({{2{rot_ang[31]}}, rot_ang});
    neg_load = 1'b0;
    z_load = zs;
    if (zs > QUARTER) begin
      z_load = zs - HALF;
      neg_load = 1'b1;
    end else if (zs < -QUARTER) begin
      z_load = zs + HALF;
      neg_load = 1'b1;
    end
    x_fin = rot_neg ? -x : x;
  end

  // multiplier operand select
  logic signed [33:0] mul_a, mul_b, p30, mul_p34;
  logic signed [17:0] cs;
  logic signed [15:0] qu;
  logic [23:0] wsel;
  logic signed [67:0] prod_sh;
  logic signed [47:0] rr;
  logic [79:0] v80;
  logic [47:0] wsq;
  logic [48:0] term_sum;
  logic big;

  always_comb begin
    prod_sh = prod >>> 30;
    p30 = 34'(prod_sh);
    mul_p34 = 34'(prod);
    cs = sel ? s16 : c16;
    qu = sel ? u_in : q_in;
    wsel = sel ? weight_u : weight_q;
    mul_a = '0;
    mul_b = '0;
    case (step)
      STEP_K0: begin mul_a = sa; mul_b = sd; end
      STEP_K1: begin mul_a = sx; mul_b = ca; end
      STEP_K2: begin mul_a = cx; mul_b = sa; end
      STEP_K3: begin mul_a = p30; mul_b = cd; end
      STEP_L0: begin mul_a = 34'(q_in); mul_b = 34'(c16); end
      STEP_L1: begin mul_a = mul_p34; mul_b = $signed({10'b0, weight_q}); end
      STEP_L2: begin mul_a = 34'(u_in); mul_b = 34'(s16); end
      STEP_L3: begin mul_a = mul_p34; mul_b = $signed({10'b0, weight_u}); end
      STEP_L4: begin mul_a = 34'(c16); mul_b = 34'(c16); end
      STEP_L5: begin mul_a = mul_p34; mul_b = $signed({10'b0, weight_q}); end
      STEP_L6: begin mul_a = 34'(s16); mul_b = 34'(s16); end
      STEP_L7: begin mul_a = mul_p34; mul_b = $signed({10'b0, weight_u}); end
      STEP_R0: begin mul_a = $signed({{11{ln[45]}}, ln[45:23]}); mul_b = 34'(cs); end
      STEP_R1: begin mul_a = $signed({11'b0, ln[22:0]}); mul_b = 34'(cs); end
      STEP_W0: begin
        mul_a = $signed({14'b0, mag[39:20]});
        mul_b = $signed({14'b0, mag[39:20]});
      end
      STEP_W1: begin
        mul_a = $signed({14'b0, mag[39:20]});
        mul_b = $signed({14'b0, mag[19:0]});
      end
      STEP_W2: begin
        mul_a = $signed({14'b0, mag[19:0]});
        mul_b = $signed({14'b0, mag[19:0]});
      end
      STEP_W4: begin mul_a = $signed({2'b0, acc[47:16]}); mul_b = $signed({10'b0, wsel}); end
      STEP_W5: begin mul_a = $signed({2'b0, acc[79:48]}); mul_b = $signed({10'b0, wsel}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    rr = (48'(qu) <<< 16) - 48'(acc >>> 16);
    big = |mag[47:40];
    v80 = 80'(acc >>> 16);
    if (wsel == '0) wsq = '0;
    else if (big || v80 > 80'(rvm_pcs_pkg::MAX48)) wsq = rvm_pcs_pkg::MAX48;
    else wsq = v80[47:0];
    term_sum = {1'b0, term} + {1'b0, wsq};
  end

  // divider step
  logic [42:0] dsh;
  logic [43:0] ddiff;
  logic [41:0] dd;
  logic [44:0] qclamp;
  logic [57:0] num_mag;

  always_comb begin
    dd = 42'(den >>> 16);
    dsh = {rem, dq[56]};
    ddiff = {1'b0, dsh} - {2'b0, dd};
    qclamp = (dq > 57'(LN_LIMIT)) ? LN_LIMIT : dq[44:0];
    num_mag = num[57] ? 58'(-num) : 58'(num);
  end

  // output and running sum
  logic [48:0] sum_raw;
  logic [47:0] sum_new;
  logic sat_new, load_out;

  always_comb begin
    sum_raw = {1'b0, running} + {1'b0, term};
    if (sum_raw >= 49'(rvm_pcs_pkg::MAX48)) begin
      sum_new = rvm_pcs_pkg::MAX48;
      sat_new = 1'b1;
    end else begin
      sum_new = sum_raw[47:0];
      sat_new = sat_flag;
    end
    load_out = (state == ST_FIN) && (!o_valid || result.ready);
  end

  assign sample.ready = (state == ST_IDLE);
  assign result.valid = o_valid;
  assign result.point_term = o_term;
  assign result.chi_square_sum = o_sum;
  assign result.sum_complete = o_complete;
  assign result.sum_saturated = o_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_angle <= '0;
      beta_angle <= '0;
      phase_offset <= '0;
      angle_offset <= '0;
      weight_q <= 24'd65536;
      weight_u <= 24'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rvm_pcs_pkg::REG_ALPHA:    alpha_angle <= cfg_data[15:0];
        rvm_pcs_pkg::REG_BETA:     beta_angle <= cfg_data[15:0];
        rvm_pcs_pkg::REG_PHASE:    phase_offset <= cfg_data[15:0];
        rvm_pcs_pkg::REG_PSI:      angle_offset <= cfg_data[15:0];
        rvm_pcs_pkg::REG_WEIGHT_Q: weight_q <= cfg_data;
        rvm_pcs_pkg::REG_WEIGHT_U: weight_u <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (sample.valid && sample.ready) begin
      phase_in <= sample.pulse_phase;
      q_in <= sample.stokes_q;
      u_in <= sample.stokes_u;
      last_in <= sample.last_bin;
    end
    unique case (state)
      ST_ROT_LOAD: begin
        x <= CORDIC_START;
        y <= '0;
        z <= z_load;
        rot_neg <= neg_load;
        vec_mode <= 1'b0;
        cnt <= '0;
      end
      ST_ROT_ITER, ST_VEC_ITER: begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        cnt <= cnt + 1'b1;
        if (state == ST_VEC_ITER && cnt == CNT_LAST) begin
          two_pa <= psi2 - {z_next[30:0], 1'b0};
        end
      end
      ST_ROT_DONE: begin
        case (rot_idx)
          ROT_ALPHA: begin ca <= 34'(x_fin); sa <= 34'(rot_neg ? -y : y); end
          ROT_SUM:   begin cx <= 34'(x_fin); sx <= 34'(rot_neg ? -y : y); end
          ROT_DIFF:  begin cd <= 34'(x_fin); sd <= 34'(rot_neg ? -y : y); end
          default: begin
            c16 <= to_q16(x_fin);
            s16 <= to_q16(rot_neg ? -y : y);
          end
        endcase
      end
      ST_VEC_LOAD: begin
        if (k1 == '0 && k2 == '0) begin
          two_pa <= psi2;
        end else begin
          x <= k2[33] ? -36'(k2) : 36'(k2);
          y <= k2[33] ? -36'(k1) : 36'(k1);
          z <= k2[33] ? HALF : '0;
          vec_mode <= 1'b1;
          cnt <= '0;
        end
      end
      ST_MUL: begin
        case (step)
          STEP_K1: k1 <= p30;
          STEP_K2: k2 <= p30;
          STEP_K4: k2 <= k2 - p30;
          STEP_L2: num <= 58'(prod);
          STEP_L4: num <= num + 58'(prod);
          STEP_L6: den <= 58'(prod);
          STEP_L8: den <= den + 58'(prod);
          STEP_R1: acc <= 96'(prod) <<< 23;
          STEP_R2: acc <= acc + 96'(prod);
          STEP_R3: mag <= rr[47] ? 48'(-rr) : 48'(rr);
          STEP_W1: acc <= 96'(prod) <<< 40;
          STEP_W2: acc <= acc + (96'(prod) <<< 21);
          STEP_W3: acc <= acc + 96'(prod);
          STEP_W5: acc <= 96'(prod);
          STEP_W6: acc <= acc + (96'(prod) <<< 32);
          STEP_W7: begin
            if (!sel) term <= wsq;
            else term <= term_sum[48] ? rvm_pcs_pkg::MAX48 : term_sum[47:0];
          end
          default: ;
        endcase
      end
      ST_DIV_LOAD: begin
        ln <= '0;
        dq <= num_mag[56:0];
        rem <= '0;
        dcnt <= '0;
      end
      ST_DIV_ITER: begin
        if (!ddiff[43]) begin
          rem <= ddiff[41:0];
          dq <= {dq[55:0], 1'b1};
        end else begin
          rem <= dsh[41:0];
          dq <= {dq[55:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      ST_DIV_DONE: ln <= num[57] ? -46'(qclamp) : 46'(qclamp);
      default: ;
    endcase
    if (load_out) begin
      o_term <= term;
      o_sum <= sum_new;
      o_complete <= last_in;
      o_sat <= sat_new;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rot_idx <= ROT_ALPHA;
      step <= STEP_K0;
      sel <= 1'b0;
      o_valid <= 1'b0;
      running <= '0;
      sat_flag <= 1'b0;
    end else begin
      if (load_out) begin
        o_valid <= 1'b1;
        running <= last_in ? '0 : sum_new;
        sat_flag <= last_in ? 1'b0 : sat_new;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            rot_idx <= ROT_ALPHA;
            state <= ST_ROT_LOAD;
          end
        end
        ST_ROT_LOAD: state <= ST_ROT_ITER;
        ST_ROT_ITER: if (cnt == CNT_LAST) state <= ST_ROT_DONE;
        ST_ROT_DONE: begin
          case (rot_idx)
            ROT_ALPHA: begin rot_idx <= ROT_SUM; state <= ST_ROT_LOAD; end
            ROT_SUM:   begin rot_idx <= ROT_DIFF; state <= ST_ROT_LOAD; end
            ROT_DIFF:  begin step <= STEP_K0; state <= ST_MUL; end
            default:   begin step <= STEP_L0; state <= ST_MUL; end
          endcase
        end
        ST_VEC_LOAD: begin
          if (k1 == '0 && k2 == '0) begin
            rot_idx <= ROT_PA;
            state <= ST_ROT_LOAD;
          end else begin
            state <= ST_VEC_ITER;
          end
        end
        ST_VEC_ITER: begin
          if (cnt == CNT_LAST) begin
            rot_idx <= ROT_PA;
            state <= ST_ROT_LOAD;
          end
        end
        ST_MUL: begin
          case (step)
            STEP_K4: state <= ST_VEC_LOAD;
            STEP_L8: state <= ST_DIV_LOAD;
            STEP_W7: begin
              if (sel) begin
                state <= ST_FIN;
              end else begin
                sel <= 1'b1;
                step <= STEP_R0;
              end
            end
            default: step <= step_t'(step + 1'b1);
          endcase
        end
        ST_DIV_LOAD: begin
          sel <= 1'b0;
          step <= STEP_R0;
          state <= (dd == '0) ? ST_MUL : ST_DIV_ITER;
        end
        ST_DIV_ITER: if (dcnt == 6'd56) state <= ST_DIV_DONE;
        ST_DIV_DONE: state <= ST_MUL;
        ST_FIN: if (load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/rvm_pcs_checker.sv]
// port checker for rvm_polarization_chi_square, bound to the top level
// depends on rvm_pcs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rvm_polarization_chi_square_macros.svh"

module rvm_pcs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [rvm_pcs_pkg::RES_W-1:0] point_term,
  input logic [rvm_pcs_pkg::RES_W-1:0] chi_square_sum,
  input logic sum_saturated
);

  `RVM_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `RVM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(chi_square_sum))
  `RVM_ASSERT_IMP(a_sum_covers_term, clk, rst, out_valid, chi_square_sum >= point_term)
  `RVM_ASSERT_IMP(a_sat_means_max, clk, rst, out_valid && sum_saturated, chi_square_sum == rvm_pcs_pkg::MAX48)

endmodule

bind rvm_polarization_chi_square rvm_pcs_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(sample.valid),
  .in_ready(sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .point_term(result.point_term),
  .chi_square_sum(result.chi_square_sum),
  .sum_saturated(result.sum_saturated)
);

[bench/testbench.sv]
// self-checking bench for the rotating-vector-model chi-square block
// depends on rvm_pcs_pkg, rvm_pcs_if and rvm_polarization_chi_square
`timescale 1ns / 1ps

module testbench;

  localparam longint CORDIC_GAIN0 = 64'd652032874;
  localparam longint HALF_T = 64'd2147483648;
  localparam longint QUARTER_T = 64'd1073741824;
  localparam longint FULL_T = 64'd4294967296;
  localparam longint AMP_LIMIT = 64'd17592186044416;
  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam longint ATAN_TBL [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  typedef struct {
    logic [47:0] term;
    logic [47:0] sum;
    logic        complete;
    logic        saturated;
  } chi_word_t;

  typedef struct {
    logic [15:0] phase;
    logic [15:0] q;
    logic [15:0] u;
    logic        last;
    bit          typed;
    logic [47:0] term;
    logic [47:0] sum;
  } bin_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [rvm_pcs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rvm_pcs_pkg::W_W-1:0] cfg_data;

  rvm_pcs_in_if bin_ch();
  rvm_pcs_out_if res_ch();

  rvm_polarization_chi_square dut (
    .clk(clk), .rst(rst), .sample(bin_ch), .result(res_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] m_alpha, m_beta, m_phi0, m_psi0;
  logic [23:0] m_wq, m_wu;
  logic [47:0] m_chi_sum;
  logic        m_sat;

  chi_word_t   chi_expected[$];
  int          errors = 0;
  int          results_seen = 0;
  int          stall_left = 0;
  bit          stall_done = 0;
  bit          no_idle = 0;
  int          quiet_cycles = 0;

  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    longint z, x, y, dx, dy;
    bit neg;
    z = longint'({32'b0, ang});
    x = CORDIC_GAIN0;
    y = 0;
    neg = 0;
    if (z >= HALF_T) z -= FULL_T;
    if (z > QUARTER_T) begin
      z -= HALF_T;
      neg = 1;
    end else if (z < -QUARTER_T) begin
      z += HALF_T;
      neg = 1;
    end
    for (int i = 0; i < rvm_pcs_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [31:0] cordic_atan2(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_T;
    end
    for (int i = 0; i < rvm_pcs_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z[31:0];
  endfunction

  function automatic logic [47:0] weighted_sq(input longint r, input longint w);
    logic [127:0] m, sq, pr;
    if (w == 0) return '0;
    m = (r < 0) ? -r : r;
    sq = m * m;
    if ((sq >> 80) != 0) return SAT48;
    pr = (sq >> 16) * w;
    if ((pr >> 80) != 0) return SAT48;
    pr = pr >> 16;
    if (pr > SAT48) return SAT48;
    return pr[47:0];
  endfunction

  function automatic longint round_q16(input longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic chi_word_t predict_bin(input logic [15:0] phase, input logic [15:0] qs,
                                            input logic [15:0] us, input logic last);
    chi_word_t o;
    longint sa, ca, sx, cx, sd, cd, k1, k2, c, s, c16, s16;
    longint q, u, wq, wu, num, den, dd, ln, rq, ru;
    logic [15:0] ab, dphi;
    logic [31:0] psi2, two_pa;
    logic [48:0] t, sm;
    q = longint'($signed(qs));
    u = longint'($signed(us));
    wq = longint'({40'b0, m_wq});
    wu = longint'({40'b0, m_wu});
    ab = m_alpha + m_beta;
    dphi = phase - m_phi0;
    psi2 = {m_psi0[14:0], 17'b0};
    cordic_sincos({m_alpha, 16'b0}, ca, sa);
    cordic_sincos({ab, 16'b0}, cx, sx);
    cordic_sincos({dphi, 16'b0}, cd, sd);
    k1 = (sa * sd) >>> 30;
    k2 = ((sx * ca) >>> 30) - ((((cx * sa) >>> 30) * cd) >>> 30);
    if (k1 == 0 && k2 == 0) two_pa = psi2;
    else two_pa = psi2 - 32'd2 * cordic_atan2(k2, k1);
    cordic_sincos(two_pa, c, s);
    c16 = round_q16(c);
    s16 = round_q16(s);
    num = q * c16 * wq + u * s16 * wu;
    den = c16 * c16 * wq + s16 * s16 * wu;
    dd = den >>> 16;
    ln = (dd != 0) ? num / dd : 0;
    if (ln > AMP_LIMIT) ln = AMP_LIMIT;
    if (ln < -AMP_LIMIT) ln = -AMP_LIMIT;
    rq = q * 65536 - ((ln * c16) >>> 16);
    ru = u * 65536 - ((ln * s16) >>> 16);
    t = {1'b0, weighted_sq(rq, wq)} + {1'b0, weighted_sq(ru, wu)};
    if (t > SAT48) t = {1'b0, SAT48};
    sm = {1'b0, m_chi_sum} + t;
    if (sm >= SAT48) begin
      sm = {1'b0, SAT48};
      m_sat = 1;
    end
    m_chi_sum = sm[47:0];
    o.term = t[47:0];
    o.sum = sm[47:0];
    o.complete = last;
    o.saturated = m_sat;
    if (last) begin
      m_chi_sum = '0;
      m_sat = 0;
    end
    return o;
  endfunction

  task automatic write_reg(input rvm_pcs_pkg::cfg_reg_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      rvm_pcs_pkg::REG_ALPHA:    m_alpha = val[15:0];
      rvm_pcs_pkg::REG_BETA:     m_beta = val[15:0];
      rvm_pcs_pkg::REG_PHASE:    m_phi0 = val[15:0];
      rvm_pcs_pkg::REG_PSI:      m_psi0 = val[15:0];
      rvm_pcs_pkg::REG_WEIGHT_Q: m_wq = val;
      rvm_pcs_pkg::REG_WEIGHT_U: m_wu = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_geometry(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] p0, input logic [15:0] s0,
                               input logic [23:0] wq, input logic [23:0] wu);
    while (chi_expected.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    write_reg(rvm_pcs_pkg::REG_ALPHA, {8'b0, a});
    write_reg(rvm_pcs_pkg::REG_BETA, {8'b0, b});
    write_reg(rvm_pcs_pkg::REG_PHASE, {8'b0, p0});
    write_reg(rvm_pcs_pkg::REG_PSI, {8'b0, s0});
    write_reg(rvm_pcs_pkg::REG_WEIGHT_Q, wq);
    write_reg(rvm_pcs_pkg::REG_WEIGHT_U, wu);
  endtask

  task automatic send_bin(input bin_row_t row);
    chi_word_t w;
    while (!no_idle && $urandom_range(99) < 36) begin
      bin_ch.valid = 1'b0;
      @(negedge clk);
    end
    bin_ch.pulse_phase = row.phase;
    bin_ch.stokes_q = row.q;
    bin_ch.stokes_u = row.u;
    bin_ch.last_bin = row.last;
    bin_ch.valid = 1'b1;
    do @(posedge clk); while (!bin_ch.ready);
    w = predict_bin(row.phase, row.q, row.u, row.last);
    if (row.typed) begin
      w.term = row.term;
      w.sum = row.sum;
    end
    chi_expected.push_back(w);
    @(negedge clk);
    bin_ch.valid = 1'b0;
  endtask

  function automatic bin_row_t random_bin();
    bin_row_t r;
    r.phase = 16'($urandom());
    r.q = 16'($urandom());
    r.u = 16'($urandom());
    if ($urandom_range(3) == 0) begin
      r.q = $signed(r.q) >>> $urandom_range(15, 4);
      r.u = $signed(r.u) >>> $urandom_range(15, 4);
    end
    r.last = ($urandom_range(15) == 0);
    r.typed = 0;
    r.term = '0;
    r.sum = '0;
    return r;
  endfunction

  // receiver side
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && results_seen >= 60) begin
        stall_done = 1;
        stall_left = 700;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready = 1'b0;
      end else begin
        res_ch.ready = no_idle || ($urandom_range(99) >= 36);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    chi_word_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (chi_expected.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = chi_expected.pop_front();
        if (res_ch.point_term !== e.term) begin
          $error("point_term exp %0d got %0d", e.term, res_ch.point_term);
          errors++;
        end
        if (res_ch.chi_square_sum !== e.sum) begin
          $error("chi_square_sum exp %0d got %0d", e.sum, res_ch.chi_square_sum);
          errors++;
        end
        if (res_ch.sum_complete !== e.complete) begin
          $error("sum_complete exp %0d got %0d", e.complete, res_ch.sum_complete);
          errors++;
        end
        if (res_ch.sum_saturated !== e.saturated) begin
          $error("sum_saturated exp %0d got %0d", e.saturated, res_ch.sum_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (bin_ch.valid && bin_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  bin_row_t directed_bins[] = '{
    '{16'd0,     16'h0000, 16'h0000, 1'b0, 1, 48'd0, 48'd0},
    '{16'd65535, 16'h0000, 16'h0000, 1'b1, 1, 48'd0, 48'd0},
    '{16'd0,     16'h7FFF, 16'h0000, 1'b0, 0, 48'd0, 48'd0},
    '{16'd16384, 16'h8000, 16'h7FFF, 1'b0, 0, 48'd0, 48'd0},
    '{16'd32768, 16'h0000, 16'h8000, 1'b0, 0, 48'd0, 48'd0},
    '{16'd49152, 16'hFFFF, 16'h0001, 1'b1, 0, 48'd0, 48'd0},
    '{16'd65535, 16'h8000, 16'h8000, 1'b0, 0, 48'd0, 48'd0},
    '{16'd1,     16'h7FFF, 16'h7FFF, 1'b1, 0, 48'd0, 48'd0},
    '{16'hAAAA,  16'h5555, 16'hAAAA, 1'b0, 0, 48'd0, 48'd0},
    '{16'h5555,  16'hAAAA, 16'h5555, 1'b1, 0, 48'd0, 48'd0}
  };

  initial begin
    bin_row_t r;
    bin_ch.valid = 1'b0;
    bin_ch.pulse_phase = '0;
    bin_ch.stokes_q = '0;
    bin_ch.stokes_u = '0;
    bin_ch.last_bin = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_alpha = '0; m_beta = '0; m_phi0 = '0; m_psi0 = '0;
    m_wq = 24'd65536; m_wu = 24'd65536;
    m_chi_sum = '0;
    m_sat = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry: degenerate, pa equals psi0
    foreach (directed_bins[i]) send_bin(directed_bins[i]);

    // zero weights: every term vanishes
    load_geometry(16'd0, 16'd0, 16'd0, 16'h4000, 24'd0, 24'd0);
    foreach (directed_bins[i]) begin
      r = directed_bins[i];
      r.typed = 1;
      r.term = '0;
      r.sum = '0;
      send_bin(r);
    end

    // extremes, heavy weights push the sum into saturation
    load_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    for (int i = 0; i < 120; i++) send_bin(random_bin());

    // right-angle inclination, k2 near zero
    load_geometry(16'd16384, 16'd0, 16'd1234, 16'd0, 24'd1, 24'd1);
    for (int i = 0; i < 150; i++) send_bin(random_bin());

    for (int p = 0; p < 5; p++) begin
      load_geometry(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                    24'($urandom_range(24'hFFFFFF, 1)), 24'($urandom_range(24'hFFFFFF, 1)));
      for (int i = 0; i < 230; i++) begin
        no_idle = (p == 2 && i >= 50 && i < 200);
        send_bin(random_bin());
      end
      no_idle = 0;
    end
    bin_ch.valid = 1'b0;

    while (chi_expected.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/rvm_pcs_pkg.sv
src/rvm_pcs_if.sv
src/rvm_polarization_chi_square.sv
src/rvm_pcs_checker.sv
bench/testbench.sv
